// File: hw/rtl/ssc_pkg.sv
// Shared types, constants and the gap table for the Shell sort block.
package ssc_pkg;

  // Store geometry
  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int KEY_W     = 32;
  localparam int TAG_BITS  = 16;
  localparam int DATA_W    = KEY_W + TAG_BITS;

  // Gap sequence
  localparam int GAP_COUNT = 6;
  localparam int GIDX_W    = $clog2(GAP_COUNT);
  localparam int GAP_W     = 8;

  // One stored record; key sits in the low bits
  typedef struct packed {
    logic [TAG_BITS-1:0]    tag;
    logic signed [KEY_W-1:0] key;
  } rec_t;

  // Gap for a given table index, ascending with the index
  function automatic logic [GAP_W-1:0] gap_of(input logic [GIDX_W-1:0] idx);
    logic [GAP_W-1:0] g;
    case (idx)
      3'd0:    g = 8'd1;
      3'd1:    g = 8'd4;
      3'd2:    g = 8'd10;
      3'd3:    g = 8'd23;
      3'd4:    g = 8'd57;
      3'd5:    g = 8'd132;
      default: g = 8'd1;
    endcase
    return g;
  endfunction

endpackage

// File: hw/rtl/shell_sort_ciura_gaps.sv
// Top level: record loader, Shell sort sequencer and sorted-record output.
//
// Records load at one transfer per cycle into a 64-entry store; a record that arrives when
// the store is full is dropped, and the transfer with tlast closes the set. The block then
// drops s_tready and sorts in place by gapped insertion passes (gaps 1,4,10,23,57 from the
// largest below the count down to 1), one store access per cycle through a single read port
// and a single comparator: each insertion fetches its record (S_IRD, S_ICAP), reads and
// compares each predecessor (S_JRD, S_JCMP), moving it up one gap while it is larger, then
// places the held record, directly from S_JRD when the walk reaches the bottom of the gap.
// The first gap is picked in S_GSEL. Sorted records are then sent out ascending by signed
// key, each read (S_ORD), captured (S_OCAP) and held (S_OHLD) until taken, with tlast on
// the final one; after that the block is ready for a new set.
module shell_sort_ciura_gaps
  import ssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // s_tdata fields from bit 0: key[31:0], payload[47:32]
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              s_tlast,
  // m_tdata fields from bit 0: key_res[31:0], payload_res[47:32]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,
  output logic              m_tlast
);

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_GSEL = 9'b000000010,
    S_IRD  = 9'b000000100,
    S_ICAP = 9'b000001000,
    S_JRD  = 9'b000010000,
    S_JCMP = 9'b000100000,
    S_ORD  = 9'b001000000,
    S_OCAP = 9'b010000000,
    S_OHLD = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [GIDX_W-1:0]  gidx, gidx_next;
  logic [CNT_W-1:0]   i, i_next;
  logic [ADDR_W-1:0]  j, j_next;
  logic [ADDR_W-1:0]  o, o_next;
  rec_t               hold, hold_next;
  rec_t               out_rec, out_rec_next;
  logic               out_valid, out_valid_next;
  logic               out_last, out_last_next;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  rec_t               mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  rec_t               mem_rdata;
  logic               key_lt;

  logic [GAP_W-1:0]   gap_cur;
  logic [GIDX_W-1:0]  gidx_start;
  logic [CNT_W-1:0]   i_inc;
  logic [GAP_W-1:0]   gap_lower;
  logic               j_ge_gap;
  logic               s_xfer;
  logic               m_xfer;

  ssc_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ssc_cmp u_cmp (
    .a  (hold.key),
    .b  (mem_rdata.key),
    .lt (key_lt)
  );

  assign s_tready = (state == S_LOAD);
  assign s_xfer   = s_tvalid & s_tready;
  assign m_xfer   = out_valid & m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_rec;
  assign m_tlast  = out_last;

  assign gap_cur   = gap_of(gidx);
  assign gap_lower = gap_of(gidx - GIDX_W'(1));
  assign i_inc     = i + CNT_W'(1);
  assign j_ge_gap  = (GAP_W'(j) >= gap_cur);

  // Pick the largest gap below the count; a gap equal to the count has no work
  always_comb begin
    gidx_start = '0;
    for (int g = 1; g < GAP_COUNT; g++) begin
      if (gap_of(GIDX_W'(g)) < GAP_W'(count)) begin
        gidx_start = GIDX_W'(g);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next     = state;
    count_next     = count;
    gidx_next      = gidx;
    i_next         = i;
    j_next         = j;
    o_next         = o;
    hold_next      = hold;
    out_rec_next   = out_rec;
    out_valid_next = out_valid;
    out_last_next  = out_last;
    mem_we         = 1'b0;
    mem_waddr      = j;
    mem_wdata      = hold;
    mem_raddr      = j;

    unique case (state)
      S_LOAD: begin
        mem_waddr = count[ADDR_W-1:0];
        mem_wdata = s_tdata;
        if (s_xfer) begin
          if (count < CNT_W'(MAX_ITEMS)) begin
            mem_we     = 1'b1;
            count_next = count + CNT_W'(1);
          end
          if (s_tlast) begin
            state_next = S_GSEL;
          end
        end
      end
      S_GSEL: begin
        gidx_next = gidx_start;
        i_next    = CNT_W'(gap_of(gidx_start));
        if (GAP_W'(count) > gap_of(gidx_start)) begin
          state_next = S_IRD;
        end else begin
          o_next     = '0;
          state_next = S_ORD;
        end
      end
      S_IRD: begin
        mem_raddr  = i[ADDR_W-1:0];
        state_next = S_ICAP;
      end
      S_ICAP: begin
        hold_next  = mem_rdata;
        j_next     = i[ADDR_W-1:0];
        state_next = S_JRD;
      end
      S_JRD: begin
        mem_raddr = j - ADDR_W'(gap_cur);
        if (j_ge_gap) begin
          state_next = S_JCMP;
        end else begin
          // Place the held record and advance the insertion index
          mem_we = 1'b1;
          if (i_inc < count) begin
            i_next     = i_inc;
            state_next = S_IRD;
          end else if (gidx == '0) begin
            o_next     = '0;
            state_next = S_ORD;
          end else begin
            gidx_next  = gidx - GIDX_W'(1);
            i_next     = CNT_W'(gap_lower);
            state_next = S_IRD;
          end
        end
      end
      S_JCMP: begin
        if (key_lt) begin
          // Shift the predecessor up one gap and keep walking
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata;
          j_next     = j - ADDR_W'(gap_cur);
          state_next = S_JRD;
        end else begin
          mem_we = 1'b1;
          if (i_inc < count) begin
            i_next     = i_inc;
            state_next = S_IRD;
          end else if (gidx == '0) begin
            o_next     = '0;
            state_next = S_ORD;
          end else begin
            gidx_next  = gidx - GIDX_W'(1);
            i_next     = CNT_W'(gap_lower);
            state_next = S_IRD;
          end
        end
      end
      S_ORD: begin
        mem_raddr  = o;
        state_next = S_OCAP;
      end
      S_OCAP: begin
        out_rec_next   = mem_rdata;
        out_valid_next = 1'b1;
        out_last_next  = ((CNT_W'(o) + CNT_W'(1)) == count);
        state_next     = S_OHLD;
      end
      S_OHLD: begin
        if (m_xfer) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            count_next = '0;
            state_next = S_LOAD;
          end else begin
            o_next     = o + ADDR_W'(1);
            state_next = S_ORD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // Indexes and payload registers
  always_ff @(posedge clk) begin
    gidx     <= gidx_next;
    i        <= i_next;
    j        <= j_next;
    o        <= o_next;
    hold     <= hold_next;
    out_rec  <= out_rec_next;
    out_last <= out_last_next;
  end

  // Input and output never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while a result is pending");

  // Store never overfills
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("record count beyond store depth");

  // A compare only happens with a predecessor in range
  a_cmp_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_JCMP) |-> j_ge_gap)
    else $error("compare against a slot below zero");

  // Final result returns the block to loading with an empty set
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (m_xfer && m_tlast) |=> (s_tready && count == '0))
    else $error("set not closed after final result");

endmodule

// File: hw/rtl/ssc_mem.sv
// Record store: one write port and one read port with registered read data.
module ssc_mem
  import ssc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  rec_t              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output rec_t              rdata
);

  rec_t mem [MAX_ITEMS];

  // Write, and read into a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ssc_cmp.sv
// Shared key comparator: signed strict less-than.
module ssc_cmp
  import ssc_pkg::*;
(
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output logic                    lt
);

  assign lt = (a < b);

endmodule
